// File: sv/pmft_pkg.sv
// Shared types and constants for the page-mapped flash translation block.
// Used by the top level; the generic RAM stands alone.
package pmft_pkg;

  localparam int unsigned NUM_BLOCKS         = 16;
  localparam int unsigned BLOCK_PAGES        = 8;
  localparam int unsigned TOTAL_PAGES        = NUM_BLOCKS * BLOCK_PAGES;
  localparam int unsigned MAX_LOGICAL_BLOCKS = 128;
  localparam int unsigned BLK_W              = $clog2(NUM_BLOCKS);
  localparam int unsigned PIB_W              = $clog2(BLOCK_PAGES);
  localparam int unsigned PAGE_W             = $clog2(TOTAL_PAGES);
  localparam int unsigned LB_W               = $clog2(MAX_LOGICAL_BLOCKS);
  localparam int unsigned MAX_RESULTS        = 34;
  localparam int unsigned RES_DEPTH          = 64;
  localparam int unsigned RES_AW             = $clog2(RES_DEPTH);

  typedef enum logic [2:0] {
    CMD_NONE       = 3'd0,
    CMD_READ_HOST  = 3'd1,
    CMD_READ_SLOT  = 3'd2,
    CMD_ERASE      = 3'd3,
    CMD_WRITE_HOST = 3'd4,
    CMD_WRITE_SLOT = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    STS_OK           = 3'd0,
    STS_UNWRITTEN    = 3'd1,
    STS_OUT_OF_RANGE = 3'd2,
    STS_INCONSISTENT = 3'd3,
    STS_NO_FREE      = 3'd4,
    STS_LOST         = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    PG_FREE    = 2'd0,
    PG_VALID   = 2'd1,
    PG_INVALID = 2'd2
  } pstate_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [6:0] page;
    logic [3:0] blk;
    logic [2:0] slot;
    status_e    status;
  } res_t;

  typedef struct packed {
    logic [LB_W-1:0] lb;
    pstate_e         st;
  } page_t;

endpackage

// File: sv/pmft_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module pmft_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/page_mapped_flash_translation.sv
// Top level of the page-mapped flash translation block.
// Depends on pmft_pkg and pmft_ram (map, page status and result memories).
//
// A request is taken when start is high and busy is low; busy stays high until the
// last result of that request has been shown. Results come one per cycle with
// valid_o and cannot be held off; the final one carries last_o. All results of a
// request are collected in a result memory and played out once the request is
// finished, so every result carries the final read and write counts. A rejected
// request or an unwritten read goes from dispatch straight to playing out its
// result; a mapped read first reads its page. A write is bound by the page status
// memory, read one page a cycle: a write runs a free-page search and, if none is
// found, an invalid-page count, a cleaning of the block with the most invalid
// pages and another search, then if need be a least-erased search, a cleaning of
// that block and a last search. Each cleaning reads its block, erases it, and
// runs one free-page search per migrated page. No clearing pass follows reset.
module page_mapped_flash_translation (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i,
  input  logic       op_i,
  input  logic [7:0] logical_block_i,
  output logic       valid_o,
  output logic [2:0] command_o,
  output logic [6:0] page_address_o,
  output logic [3:0] erase_block_o,
  output logic [2:0] buffer_slot_o,
  output logic [2:0] status_o,
  output logic [31:0] reads_done_o,
  output logic [31:0] writes_done_o,
  output logic       last_o
);
  import pmft_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_RD_PAGE, S_FF, S_GC, S_MIN,
    S_CL_RD, S_CL_ERASE, S_CL_MIG, S_W_INV, S_W_NEW, S_DRAIN
  } state_e;

  typedef enum logic [1:0] {
    R_FIRST, R_MIGRATE, R_AFTER_GREEDY, R_AFTER_MIN
  } ret_e;

  state_e state_q, state_d;
  ret_e   ret_q, ret_d;
  logic              op_q, op_d;
  logic [LB_W-1:0]   lb_q, lb_d;
  logic              oor_q, oor_d;
  logic [7:0]        lim_q;
  logic [31:0]       rd_cnt_q, rd_cnt_d, wr_cnt_q, wr_cnt_d;
  logic [RES_AW-1:0] rcnt_q, rcnt_d, k_q, k_d;
  logic              dv_q, dv_d, dl_q, dl_d;
  logic [PAGE_W:0]   sc_q, sc_d;
  logic              rv_q, rv_d;
  logic [PAGE_W-1:0] ra_q, ra_d, np_q, np_d;
  logic              found_q, found_d;
  logic [31:0]       best_q, best_d;
  logic              skip_en_q, skip_en_d;
  logic [BLK_W-1:0]  skip_q, skip_d, bestb_q, bestb_d, cl_blk_q, cl_blk_d;
  logic [PIB_W:0]    gcnt_q, gcnt_d, bestn_q, bestn_d, n_q, n_d, i_q, i_d;
  logic              clfb_q, clfb_d;
  logic [LB_W-1:0]   held_q [BLOCK_PAGES];
  logic              held_we;
  logic [31:0]       ec_q [NUM_BLOCKS];
  logic              ec_inc;
  logic [BLK_W-1:0]  ec_idx;
  logic [31:0]       ec_rd;
  logic [TOTAL_PAGES-1:0]        pv_q;
  logic [MAX_LOGICAL_BLOCKS-1:0] lmap_q;
  logic              pv_set, pv_clr, lmap_set;
  logic [PAGE_W-1:0] pv_idx;

  // Memory ports
  logic                    pg_we;
  logic [PAGE_W-1:0]       pg_waddr, pg_raddr;
  page_t                   pg_wdata;
  logic [$bits(page_t)-1:0] pg_rdata;
  page_t                   pe;
  logic                    l2p_we;
  logic [LB_W-1:0]         l2p_raddr, l2p_waddr;
  logic [PAGE_W-1:0]       l2p_wdata, l2p_rdata;
  logic                    res_we;
  res_t                    res_wdata;
  logic [$bits(res_t)-1:0] res_rdata;
  res_t                    res_out;

  logic [7:0] eff_lim;
  logic [PIB_W:0] gc_c;
  logic       take;

  function automatic res_t mk_res(cmd_e c, logic [6:0] pg, logic [3:0] b,
                                  logic [2:0] s, status_e st);
    res_t r;
    r.cmd = c;
    r.page = pg;
    r.blk = b;
    r.slot = s;
    r.status = st;
    return r;
  endfunction

  pmft_ram #(.WIDTH($bits(page_t)), .DEPTH(TOTAL_PAGES)) u_page_ram (
    .clk_i, .we_i(pg_we), .waddr_i(pg_waddr), .wdata_i(pg_wdata),
    .raddr_i(pg_raddr), .rdata_o(pg_rdata)
  );

  pmft_ram #(.WIDTH(PAGE_W), .DEPTH(MAX_LOGICAL_BLOCKS)) u_l2p_ram (
    .clk_i, .we_i(l2p_we), .waddr_i(l2p_waddr), .wdata_i(l2p_wdata),
    .raddr_i(l2p_raddr), .rdata_o(l2p_rdata)
  );

  pmft_ram #(.WIDTH($bits(res_t)), .DEPTH(RES_DEPTH)) u_res_ram (
    .clk_i, .we_i(res_we), .waddr_i(rcnt_q), .wdata_i(res_wdata),
    .raddr_i(k_q), .rdata_o(res_rdata)
  );

  assign eff_lim   = (lim_q > 8'(MAX_LOGICAL_BLOCKS)) ? 8'(MAX_LOGICAL_BLOCKS) : lim_q;
  assign l2p_raddr = (state_q == S_IDLE) ? logical_block_i[LB_W-1:0] : lb_q;
  assign pe        = pv_q[ra_q] ? page_t'(pg_rdata) : page_t'('0);
  assign ec_rd     = ec_q[ec_idx];
  assign gc_c      = gcnt_q + {{PIB_W{1'b0}}, (pe.st == PG_INVALID)};
  assign take      = (sc_q == '0) || (ec_rd < best_q);

  always_comb begin
    state_d = state_q; ret_d = ret_q; op_d = op_q; lb_d = lb_q; oor_d = oor_q;
    rd_cnt_d = rd_cnt_q; wr_cnt_d = wr_cnt_q; rcnt_d = rcnt_q; k_d = k_q;
    dv_d = dv_q; dl_d = dl_q; sc_d = sc_q; rv_d = 1'b0; ra_d = ra_q; np_d = np_q;
    found_d = found_q; best_d = best_q; skip_en_d = skip_en_q; skip_d = skip_q;
    bestb_d = bestb_q; cl_blk_d = cl_blk_q; gcnt_d = gcnt_q; bestn_d = bestn_q;
    n_d = n_q; i_d = i_q; clfb_d = clfb_q;
    held_we = 1'b0; ec_inc = 1'b0; ec_idx = ra_q[PAGE_W-1:PIB_W];
    pv_set = 1'b0; pv_clr = 1'b0; lmap_set = 1'b0; pv_idx = np_q;
    pg_we = 1'b0; pg_waddr = np_q; pg_wdata = page_t'('0); pg_raddr = '0;
    l2p_we = 1'b0; l2p_waddr = lb_q; l2p_wdata = np_q;
    res_we = 1'b0; res_wdata = mk_res(CMD_NONE, '0, '0, '0, STS_OK);

    case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d    = op_i;
          lb_d    = logical_block_i[LB_W-1:0];
          oor_d   = (logical_block_i >= eff_lim);
          rcnt_d  = '0;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (oor_q) begin
          res_we = 1'b1; res_wdata = mk_res(CMD_NONE, '0, '0, '0, STS_OUT_OF_RANGE);
          state_d = S_DRAIN;
        end else if (!op_q) begin
          if (!lmap_q[lb_q]) begin
            res_we = 1'b1; res_wdata = mk_res(CMD_NONE, '0, '0, '0, STS_UNWRITTEN);
            rd_cnt_d = rd_cnt_q + 32'd1;
            state_d = S_DRAIN;
          end else begin
            pg_raddr = l2p_rdata;
            ra_d     = l2p_rdata;
            state_d  = S_RD_PAGE;
          end
        end else begin
          sc_d = '0; found_d = 1'b0; skip_en_d = 1'b0; ret_d = R_FIRST;
          state_d = S_FF;
        end
      end
      S_RD_PAGE: begin
        if (pe.st == PG_VALID && pe.lb == lb_q) begin
          res_we = 1'b1; res_wdata = mk_res(CMD_READ_HOST, ra_q, '0, '0, STS_OK);
          rd_cnt_d = rd_cnt_q + 32'd1;
        end else begin
          res_we = 1'b1; res_wdata = mk_res(CMD_NONE, '0, '0, '0, STS_INCONSISTENT);
        end
        state_d = S_DRAIN;
      end
      S_FF: begin
        if (sc_q < (PAGE_W+1)'(TOTAL_PAGES)) begin
          pg_raddr = sc_q[PAGE_W-1:0];
          ra_d     = sc_q[PAGE_W-1:0];
          rv_d     = 1'b1;
          sc_d     = sc_q + 1'b1;
        end
        if (rv_q && pe.st == PG_FREE &&
            !(skip_en_q && ra_q[PAGE_W-1:PIB_W] == skip_q) &&
            (!found_q || ec_rd < best_q)) begin
          found_d = 1'b1;
          best_d  = ec_rd;
          np_d    = ra_q;
        end
        if (sc_q == (PAGE_W+1)'(TOTAL_PAGES) && !rv_q) begin
          case (ret_q)
            R_FIRST: begin
              if (found_q) begin
                state_d = S_W_INV;
              end else begin
                sc_d = '0; gcnt_d = '0; bestn_d = '0; bestb_d = '0;
                state_d = S_GC;
              end
            end
            R_MIGRATE: begin
              if (found_q) begin
                pg_we = 1'b1; pg_waddr = np_q;
                pg_wdata.lb = held_q[i_q[PIB_W-1:0]]; pg_wdata.st = PG_VALID;
                pv_set = 1'b1; pv_idx = np_q;
                // Remap the held logical block to its new page
                l2p_we = 1'b1; l2p_waddr = held_q[i_q[PIB_W-1:0]]; lmap_set = 1'b1;
                res_we = 1'b1;
                res_wdata = mk_res(CMD_WRITE_SLOT, np_q, '0, 3'(i_q[PIB_W-1:0]), STS_OK);
              end else begin
                res_we = 1'b1; res_wdata = mk_res(CMD_NONE, '0, '0, '0, STS_LOST);
              end
              i_d = i_q + 1'b1;
              state_d = S_CL_MIG;
            end
            R_AFTER_GREEDY: begin
              if (found_q) begin
                state_d = S_W_INV;
              end else begin
                sc_d = '0;
                state_d = S_MIN;
              end
            end
            default: begin
              if (found_q) begin
                state_d = S_W_INV;
              end else begin
                res_we = 1'b1; res_wdata = mk_res(CMD_NONE, '0, '0, '0, STS_NO_FREE);
                state_d = S_DRAIN;
              end
            end
          endcase
        end
      end
      S_GC: begin
        if (sc_q < (PAGE_W+1)'(TOTAL_PAGES)) begin
          pg_raddr = sc_q[PAGE_W-1:0];
          ra_d     = sc_q[PAGE_W-1:0];
          rv_d     = 1'b1;
          sc_d     = sc_q + 1'b1;
        end
        if (rv_q) begin
          if (ra_q[PIB_W-1:0] == {PIB_W{1'b1}}) begin
            if (gc_c > bestn_q) begin
              bestn_d = gc_c;
              bestb_d = ra_q[PAGE_W-1:PIB_W];
            end
            gcnt_d = '0;
          end else begin
            gcnt_d = gc_c;
          end
        end
        if (sc_q == (PAGE_W+1)'(TOTAL_PAGES) && !rv_q) begin
          sc_d = '0;
          if (bestn_q != '0) begin
            cl_blk_d = bestb_q; clfb_d = 1'b0; n_d = '0;
            state_d = S_CL_RD;
          end else begin
            state_d = S_MIN;
          end
        end
      end
      S_MIN: begin
        ec_idx = sc_q[BLK_W-1:0];
        if (take) begin
          best_d  = ec_rd;
          bestb_d = sc_q[BLK_W-1:0];
        end
        if (sc_q == (PAGE_W+1)'(NUM_BLOCKS - 1)) begin
          cl_blk_d = take ? sc_q[BLK_W-1:0] : bestb_q;
          clfb_d = 1'b1; n_d = '0; sc_d = '0;
          state_d = S_CL_RD;
        end else begin
          sc_d = sc_q + 1'b1;
        end
      end
      S_CL_RD: begin
        if (sc_q < (PAGE_W+1)'(BLOCK_PAGES)) begin
          pg_raddr = {cl_blk_q, sc_q[PIB_W-1:0]};
          ra_d     = {cl_blk_q, sc_q[PIB_W-1:0]};
          rv_d     = 1'b1;
          sc_d     = sc_q + 1'b1;
        end
        if (rv_q && pe.st == PG_VALID) begin
          held_we = 1'b1;
          res_we = 1'b1;
          res_wdata = mk_res(CMD_READ_SLOT, ra_q, '0, 3'(n_q[PIB_W-1:0]), STS_OK);
          n_d = n_q + 1'b1;
        end
        if (sc_q == (PAGE_W+1)'(BLOCK_PAGES) && !rv_q) begin
          state_d = S_CL_ERASE;
        end
      end
      S_CL_ERASE: begin
        pv_clr = 1'b1;
        ec_idx = cl_blk_q;
        ec_inc = 1'b1;
        res_we = 1'b1; res_wdata = mk_res(CMD_ERASE, '0, cl_blk_q, '0, STS_OK);
        i_d = '0;
        state_d = S_CL_MIG;
      end
      S_CL_MIG: begin
        sc_d = '0; found_d = 1'b0;
        if (i_q < n_q) begin
          skip_en_d = 1'b0; ret_d = R_MIGRATE;
        end else begin
          skip_en_d = 1'b1; skip_d = cl_blk_q;
          ret_d = clfb_q ? R_AFTER_MIN : R_AFTER_GREEDY;
        end
        state_d = S_FF;
      end
      S_W_INV: begin
        // Retire the old copy; the map read of lb_q runs every busy cycle.
        if (lmap_q[lb_q]) begin
          pg_we = 1'b1; pg_waddr = l2p_rdata;
          pg_wdata.lb = '0; pg_wdata.st = PG_INVALID;
          pv_set = 1'b1; pv_idx = l2p_rdata;
        end
        state_d = S_W_NEW;
      end
      S_W_NEW: begin
        pg_we = 1'b1; pg_waddr = np_q;
        pg_wdata.lb = lb_q; pg_wdata.st = PG_VALID;
        pv_set = 1'b1; pv_idx = np_q;
        l2p_we = 1'b1; lmap_set = 1'b1;
        wr_cnt_d = wr_cnt_q + 32'd1;
        res_we = 1'b1; res_wdata = mk_res(CMD_WRITE_HOST, np_q, '0, '0, STS_OK);
        state_d = S_DRAIN;
      end
      S_DRAIN: begin
        dv_d = 1'b0;
        if (k_q < rcnt_q) begin
          dv_d = 1'b1;
          dl_d = (k_q == rcnt_q - 1'b1);
          k_d  = k_q + 1'b1;
        end
        if (dv_q && dl_q) begin
          dv_d = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (res_we) begin
      rcnt_d = rcnt_q + 1'b1;
    end
    if (state_q != S_DRAIN && state_d == S_DRAIN) begin
      k_d = '0; dv_d = 1'b0; dl_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; ret_q <= R_FIRST; op_q <= 1'b0; lb_q <= '0; oor_q <= 1'b0;
      lim_q <= 8'(MAX_LOGICAL_BLOCKS);
      rd_cnt_q <= '0; wr_cnt_q <= '0; rcnt_q <= '0; k_q <= '0; dv_q <= 1'b0;
      dl_q <= 1'b0; sc_q <= '0; rv_q <= 1'b0; found_q <= 1'b0;
      skip_en_q <= 1'b0; gcnt_q <= '0; bestn_q <= '0; n_q <= '0; i_q <= '0;
      clfb_q <= 1'b0; pv_q <= '0; lmap_q <= '0;
      for (int b = 0; b < NUM_BLOCKS; b++) begin
        ec_q[b] <= '0;
      end
    end else begin
      state_q <= state_d; ret_q <= ret_d; op_q <= op_d; lb_q <= lb_d; oor_q <= oor_d;
      if (cfg_valid_i) begin
        lim_q <= cfg_data_i;
      end
      rd_cnt_q <= rd_cnt_d; wr_cnt_q <= wr_cnt_d; rcnt_q <= rcnt_d; k_q <= k_d;
      dv_q <= dv_d; dl_q <= dl_d; sc_q <= sc_d; rv_q <= rv_d; found_q <= found_d;
      skip_en_q <= skip_en_d; gcnt_q <= gcnt_d; bestn_q <= bestn_d; n_q <= n_d;
      i_q <= i_d;
      clfb_q <= clfb_d;
      if (ec_inc) begin
        ec_q[cl_blk_q] <= ec_rd + 32'd1;
      end
      if (pv_clr) begin
        for (int p = 0; p < TOTAL_PAGES; p++) begin
          if (PAGE_W'(p) >> PIB_W == PAGE_W'(cl_blk_q)) begin
            pv_q[p] <= 1'b0;
          end
        end
      end
      if (pv_set) begin
        pv_q[pv_idx] <= 1'b1;
      end
      if (lmap_set) begin
        lmap_q[l2p_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ra_q <= ra_d; np_q <= np_d; best_q <= best_d; skip_q <= skip_d;
    bestb_q <= bestb_d; cl_blk_q <= cl_blk_d;
    if (held_we) begin
      held_q[n_q[PIB_W-1:0]] <= pe.lb;
    end
  end

  assign busy           = (state_q != S_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign res_out        = res_t'(res_rdata);
  assign valid_o        = dv_q;
  assign last_o         = dv_q & dl_q;
  assign command_o      = res_out.cmd;
  assign page_address_o = res_out.page;
  assign erase_block_o  = res_out.blk;
  assign buffer_slot_o  = res_out.slot;
  assign status_o       = res_out.status;
  assign reads_done_o   = rd_cnt_q;
  assign writes_done_o  = wr_cnt_q;

  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy) else $error("result strobe outside a request");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted transaction did not raise busy");
  a_res_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rcnt_q <= RES_AW'(MAX_RESULTS)) else $error("result memory overrun");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |=> !busy) else $error("request did not end after its last result");

endmodule

// File: sim/testbench.sv
// Self-checking testbench for page_mapped_flash_translation.
// Depends on pmft_pkg and the RTL; it predicts every flash command sequence and
// compares each result strobe, field by field, with the predicted sequence.
`timescale 1ns / 100ps

module testbench;
  import pmft_pkg::*;

  localparam int unsigned STALL_LIMIT = 20000;

  typedef struct {
    cmd_e        cmd;
    bit [6:0]    page;
    bit [3:0]    blk;
    bit [2:0]    slot;
    status_e     st;
    bit [31:0]   rd;
    bit [31:0]   wr;
    bit          last;
  } flash_result_t;

  typedef struct {
    bit       op;
    bit [7:0] lb;
    bit       chk;
    cmd_e     cmd;
    bit [6:0] page;
    status_e  st;
  } request_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_data_i = 8'd0;
  logic       op_i = 1'b0;
  logic [7:0] logical_block_i = 8'd0;
  logic       valid_o;
  logic [2:0] command_o;
  logic [6:0] page_address_o;
  logic [3:0] erase_block_o;
  logic [2:0] buffer_slot_o;
  logic [2:0] status_o;
  logic [31:0] reads_done_o;
  logic [31:0] writes_done_o;
  logic       last_o;

  page_mapped_flash_translation uut (
    .clk_i, .rst_ni, .start, .busy, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .op_i, .logical_block_i, .valid_o, .command_o, .page_address_o,
    .erase_block_o, .buffer_slot_o, .status_o, .reads_done_o, .writes_done_o,
    .last_o
  );

  // Shadow translation state
  bit [7:0]  map_l2p [MAX_LOGICAL_BLOCKS];
  bit        map_lvalid [MAX_LOGICAL_BLOCKS];
  bit [7:0]  map_p2l [TOTAL_PAGES];
  bit        map_pvalid [TOTAL_PAGES];
  pstate_e   page_st [TOTAL_PAGES];
  bit [31:0] erase_cnt [NUM_BLOCKS];
  bit [31:0] host_reads;
  bit [31:0] host_writes;
  bit [7:0]  blocks_in_use;

  flash_result_t step_out[$];
  flash_result_t pending_results[$];

  int errors;
  int requests_sent;
  int results_seen;
  int cleanings;
  int idle_cycles;
  bit no_gaps;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  task automatic report(input string what);
    errors++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  function automatic void emit(cmd_e c, int pg, int b, int s, status_e st);
    flash_result_t r;
    r.cmd = c; r.page = pg[6:0]; r.blk = b[3:0]; r.slot = s[2:0]; r.st = st;
    r.rd = '0; r.wr = '0; r.last = 1'b0;
    step_out.push_back(r);
  endfunction

  // First free page of the first block with the lowest erase count
  function automatic bit find_free(input int skip, output int page);
    bit found;
    bit [31:0] best;
    found = 0;
    best = 0;
    page = 0;
    for (int b = 0; b < NUM_BLOCKS; b++) begin
      if (b == skip) continue;
      for (int p = 0; p < BLOCK_PAGES; p++) begin
        if (page_st[b*BLOCK_PAGES+p] == PG_FREE &&
            (!found || erase_cnt[b] < best)) begin
          found = 1;
          best = erase_cnt[b];
          page = b*BLOCK_PAGES + p;
        end
      end
    end
    return found;
  endfunction

  function automatic void recycle_block(input int blk);
    bit [7:0] held [BLOCK_PAGES];
    int n;
    int np;
    n = 0;
    cleanings++;
    for (int p = 0; p < BLOCK_PAGES; p++) begin
      int pg = blk*BLOCK_PAGES + p;
      if (page_st[pg] == PG_VALID && map_pvalid[pg]) begin
        held[n] = map_p2l[pg];
        emit(CMD_READ_SLOT, pg, 0, n, STS_OK);
        n++;
      end
    end
    for (int p = 0; p < BLOCK_PAGES; p++) begin
      page_st[blk*BLOCK_PAGES+p] = PG_FREE;
      map_pvalid[blk*BLOCK_PAGES+p] = 0;
    end
    erase_cnt[blk]++;
    emit(CMD_ERASE, 0, blk, 0, STS_OK);
    for (int i = 0; i < n; i++) begin
      if (find_free(-1, np)) begin
        if (held[i] < MAX_LOGICAL_BLOCKS) begin
          map_l2p[held[i]] = 8'(np);
          map_lvalid[held[i]] = 1;
        end
        map_p2l[np] = held[i];
        map_pvalid[np] = 1;
        page_st[np] = PG_VALID;
        emit(CMD_WRITE_SLOT, np, 0, i, STS_OK);
      end else begin
        emit(CMD_NONE, 0, 0, 0, STS_LOST);
      end
    end
  endfunction

  function automatic void predict_write(input int lb);
    int np;
    bit ok;
    int best_b, best_n, min_b, cnt;
    ok = find_free(-1, np);
    if (!ok) begin
      best_b = 0;
      best_n = -1;
      for (int b = 0; b < NUM_BLOCKS; b++) begin
        cnt = 0;
        for (int p = 0; p < BLOCK_PAGES; p++)
          if (page_st[b*BLOCK_PAGES+p] == PG_INVALID) cnt++;
        if (cnt > best_n) begin
          best_n = cnt;
          best_b = b;
        end
      end
      if (best_n > 0) begin
        recycle_block(best_b);
        ok = find_free(best_b, np);
      end
    end
    if (!ok) begin
      // fall back to the least-erased block
      min_b = 0;
      for (int b = 1; b < NUM_BLOCKS; b++)
        if (erase_cnt[b] < erase_cnt[min_b]) min_b = b;
      recycle_block(min_b);
      ok = find_free(min_b, np);
    end
    if (!ok) begin
      emit(CMD_NONE, 0, 0, 0, STS_NO_FREE);
      return;
    end
    if (map_lvalid[lb]) begin
      page_st[map_l2p[lb]] = PG_INVALID;
      map_pvalid[map_l2p[lb]] = 0;
    end
    map_l2p[lb] = 8'(np);
    map_lvalid[lb] = 1;
    map_p2l[np] = 8'(lb);
    map_pvalid[np] = 1;
    page_st[np] = PG_VALID;
    host_writes++;
    emit(CMD_WRITE_HOST, np, 0, 0, STS_OK);
  endfunction

  function automatic void predict_request(input bit op, input bit [7:0] lb);
    int lim;
    int pg;
    step_out.delete();
    lim = (blocks_in_use > MAX_LOGICAL_BLOCKS) ? MAX_LOGICAL_BLOCKS : blocks_in_use;
    if (lb >= lim) begin
      emit(CMD_NONE, 0, 0, 0, STS_OUT_OF_RANGE);
    end else if (op) begin
      predict_write(lb);
    end else if (!map_lvalid[lb]) begin
      host_reads++;
      emit(CMD_NONE, 0, 0, 0, STS_UNWRITTEN);
    end else begin
      pg = map_l2p[lb];
      if (page_st[pg] != PG_VALID || !map_pvalid[pg] || map_p2l[pg] != lb) begin
        emit(CMD_NONE, 0, 0, 0, STS_INCONSISTENT);
      end else begin
        host_reads++;
        emit(CMD_READ_HOST, pg, 0, 0, STS_OK);
      end
    end
    foreach (step_out[k]) begin
      step_out[k].rd = host_reads;
      step_out[k].wr = host_writes;
      step_out[k].last = (k == step_out.size() - 1);
      pending_results.push_back(step_out[k]);
    end
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  // Hold start until the transaction is taken, then predict its results
  task automatic send_request(input bit op, input bit [7:0] lb);
    int gap;
    op_i <= op;
    logical_block_i <= lb;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    predict_request(op, lb);
    requests_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0 || busy) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_limit(input bit [7:0] value);
    drain();
    cfg_data_i <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    blocks_in_use = value;
  endtask

  // Result checker: the receiver never stalls, so every strobe is a transaction
  always @(posedge clk_i) begin
    flash_result_t e;
    if (rst_ni && valid_o) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report("result strobe with nothing predicted");
      end else begin
        e = pending_results.pop_front();
        if (command_o !== e.cmd)
          report($sformatf("command %0d, predicted %0d", command_o, e.cmd));
        if (page_address_o !== e.page)
          report($sformatf("page %0d, predicted %0d", page_address_o, e.page));
        if (erase_block_o !== e.blk)
          report($sformatf("erase block %0d, predicted %0d", erase_block_o, e.blk));
        if (buffer_slot_o !== e.slot)
          report($sformatf("slot %0d, predicted %0d", buffer_slot_o, e.slot));
        if (status_o !== e.st)
          report($sformatf("status %0d, predicted %0d", status_o, e.st));
        if (reads_done_o !== e.rd)
          report($sformatf("reads_done %0d, predicted %0d", reads_done_o, e.rd));
        if (writes_done_o !== e.wr)
          report($sformatf("writes_done %0d, predicted %0d", writes_done_o, e.wr));
        if (last_o !== e.last)
          report($sformatf("last %0b, predicted %0b", last_o, e.last));
      end
    end
  end

  // Watchdog: count cycles with no transaction on any port
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || valid_o || (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", idle_cycles);
      $display("testbench failed");
      $finish;
    end
  end

  request_row_t directed_rows[] = '{
    '{0, 8'd0,   1, CMD_NONE,       7'd0, STS_UNWRITTEN},
    '{0, 8'd255, 1, CMD_NONE,       7'd0, STS_OUT_OF_RANGE},
    '{1, 8'd128, 1, CMD_NONE,       7'd0, STS_OUT_OF_RANGE},
    '{1, 8'd0,   1, CMD_WRITE_HOST, 7'd0, STS_OK},
    '{0, 8'd0,   1, CMD_READ_HOST,  7'd0, STS_OK},
    '{1, 8'd0,   1, CMD_WRITE_HOST, 7'd1, STS_OK},
    '{1, 8'd127, 1, CMD_WRITE_HOST, 7'd2, STS_OK},
    '{0, 8'd127, 1, CMD_READ_HOST,  7'd2, STS_OK},
    '{0, 8'd0,   1, CMD_READ_HOST,  7'd1, STS_OK},
    '{0, 8'd128, 1, CMD_NONE,       7'd0, STS_OUT_OF_RANGE},
    '{0, 8'd85,  1, CMD_NONE,       7'd0, STS_UNWRITTEN},
    '{1, 8'd85,  0, CMD_NONE,       7'd0, STS_OK},
    '{1, 8'd42,  0, CMD_NONE,       7'd0, STS_OK},
    '{0, 8'd42,  0, CMD_NONE,       7'd0, STS_OK},
    '{1, 8'd170, 1, CMD_NONE,       7'd0, STS_OUT_OF_RANGE}
  };

  initial begin
    bit [7:0] lb;
    for (int i = 0; i < NUM_BLOCKS; i++) erase_cnt[i] = 0;
    for (int i = 0; i < TOTAL_PAGES; i++) begin
      page_st[i] = PG_FREE;
      map_pvalid[i] = 0;
      map_p2l[i] = 0;
    end
    for (int i = 0; i < MAX_LOGICAL_BLOCKS; i++) begin
      map_lvalid[i] = 0;
      map_l2p[i] = 0;
    end
    blocks_in_use = 8'd128;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].op, directed_rows[i].lb);
      if (directed_rows[i].chk &&
          (step_out[$].cmd != directed_rows[i].cmd ||
           step_out[$].page != directed_rows[i].page ||
           step_out[$].st != directed_rows[i].st))
        report($sformatf("directed row %0d disagrees with predictor", i));
    end

    // narrow and empty windows, then a value above the maximum
    write_limit(8'd1);
    send_request(0, 8'd1);
    send_request(1, 8'd0);
    send_request(0, 8'd0);
    write_limit(8'd0);
    send_request(0, 8'd0);
    send_request(1, 8'd0);
    write_limit(8'd255);
    send_request(1, 8'd127);
    send_request(0, 8'd128);

    // rewrites on a hot set leave invalid pages for greedy cleaning
    write_limit(8'd128);
    for (int i = 0; i < 40; i++) begin
      if (i % 20 == 0) no_gaps = $urandom_range(0, 3) == 0;
      case ($urandom_range(0, 9))
        0:       send_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        1, 2:    send_request(0, 8'($urandom_range(0, 15)));
        default: send_request(1, 8'($urandom_range(0, 15)));
      endcase
    end
    no_gaps = 0;

    // fill every logical block so no page is invalid, then overrun
    lb = 0;
    for (int i = 0; i < MAX_LOGICAL_BLOCKS; i++) begin
      send_request(1, lb);
      lb++;
    end
    for (int i = 0; i < 8; i++)
      send_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 127)));

    // random windows with mixed traffic
    for (int ph = 0; ph < 3; ph++) begin
      write_limit(8'($urandom_range(1, 255)));
      for (int i = 0; i < 20; i++)
        send_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    end

    drain();
    $display("%0d requests, %0d results checked, %0d block cleanings predicted",
             requests_sent, results_seen, cleanings);
    $display("%0d mismatches", errors);
    if (errors == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule
